/* src/cfl_pkg.sv */
// ============================================================================
// cfl_pkg - shared constants for the cube face to lat/lon converter
// Fixed-point constants, stream field widths and the CORDIC angle table.
// ============================================================================
package cfl_pkg;

    // working fraction bits of the internal vector math
    localparam int WB       = 30;
    localparam int CORDIC_N = 32;

    // pi in Q.60 and its half
    localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;

    // stream widths
    localparam int FACE_W      = 3;
    localparam int COORD_W     = 17;
    localparam int UNIT_W      = 18;
    localparam int LAT_W       = 24;
    localparam int LON_W       = 25;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    // face codes
    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_POS_Y = 3'd1;
    localparam logic [2:0] FACE_POS_Z = 3'd2;
    localparam logic [2:0] FACE_NEG_X = 3'd3;
    localparam logic [2:0] FACE_NEG_Y = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    // atan(2^-idx) in Q.60: step 0 is pi/4, later steps sum the floored
    // power series terms; evaluated at elaboration only
    function automatic logic [63:0] atan_q60(input int idx);
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        acc = 64'd0;
        if (idx == 0) begin
            acc = PI_Q60 >> 2;
        end else begin
            for (int k = 0; k < 31; k++) begin
                e = 60 - idx * (2 * k + 1);
                if (e >= 0) begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    if (k[0]) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        return acc;
    endfunction

endpackage

/* src/cfl_isqrt.sv */
// ============================================================================
// cfl_isqrt - pipelined floor square root
// One result bit per register stage, with a sideband payload riding along.
// ============================================================================
module cfl_isqrt #(
    parameter int NW = 62,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_vld,
    input  logic [NW-1:0]   i_rad,
    input  logic [PW-1:0]   i_pay,
    output logic            o_vld,
    output logic [NW/2-1:0] o_root,
    output logic [PW-1:0]   o_pay
);

    localparam int RW = NW / 2;
    localparam int AW = NW + 2;

    logic [AW-1:0] r_rem  [0:RW-1];
    logic [RW-1:0] r_root [0:RW-1];
    logic [PW-1:0] r_pay  [0:RW-1];
    logic          r_vld  [0:RW-1];

    for (genvar gk = 0; gk < RW; gk++) begin : g_stage
        localparam int B = RW - 1 - gk;
        logic [AW-1:0] src_rem;
        logic [RW-1:0] src_root;
        logic [PW-1:0] src_pay;
        logic          src_vld;
        logic [AW-1:0] trial;

        if (gk == 0) begin : g_first
            assign src_rem  = {2'b00, i_rad};
            assign src_root = '0;
            assign src_pay  = i_pay;
            assign src_vld  = i_vld;
        end else begin : g_next
            assign src_rem  = r_rem[gk-1];
            assign src_root = r_root[gk-1];
            assign src_pay  = r_pay[gk-1];
            assign src_vld  = r_vld[gk-1];
        end

        // (root + 2^B)^2 - root^2
        assign trial = ({{(AW-RW){1'b0}}, src_root} << (B + 1)) + (AW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gk] <= 1'b0;
            end else if (i_ce) begin
                r_vld[gk] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_pay[gk] <= src_pay;
                if (src_rem >= trial) begin
                    r_rem[gk]  <= src_rem - trial;
                    r_root[gk] <= src_root | (RW'(1) << B);
                end else begin
                    r_rem[gk]  <= src_rem;
                    r_root[gk] <= src_root;
                end
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_pay  = r_pay[RW-1];

endmodule

/* src/cfl_atan_deg.sv */
// ============================================================================
// cfl_atan_deg - pipelined atan2 in degrees
// Quadrant fold, 32 CORDIC vectoring stages on a Q.60 angle, then a
// multiply by 180 and a restoring divide by pi, one quotient bit per stage.
// ============================================================================
module cfl_atan_deg #(
    parameter int FRAC_BITS = 16,
    parameter int PW        = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ce,
    input  logic                        i_vld,
    input  logic signed [31:0]          i_y,
    input  logic signed [31:0]          i_x,
    input  logic [PW-1:0]               i_pay,
    output logic                        o_vld,
    output logic signed [FRAC_BITS+8:0] o_deg,
    output logic [PW-1:0]               o_pay
);

    localparam int XW = 36;
    localparam int N  = cfl_pkg::CORDIC_N;
    localparam int KW = FRAC_BITS + 8;
    localparam int QB = FRAC_BITS + 8;
    localparam int NW = FRAC_BITS + 71;
    localparam int DW = FRAC_BITS + 9;
    localparam int PHW = 31 + KW;
    localparam logic [KW-1:0] KDEG  = KW'(180) << FRAC_BITS;
    localparam logic [NW-1:0] PI_N  = NW'(cfl_pkg::PI_Q60);
    localparam logic [NW-1:0] HPI_N = NW'(cfl_pkg::HALF_PI_Q60);

    // ---------------- quadrant fold ----------------
    logic signed [XW-1:0] n_p_x, n_p_y;
    logic signed [63:0]   n_p_z;
    logic signed [XW-1:0] r_p_x, r_p_y;
    logic signed [63:0]   r_p_z;
    logic                 r_p_zero;
    logic [PW-1:0]        r_p_pay;
    logic                 r_p_vld;

    always_comb begin
        n_p_x = XW'(i_x);
        n_p_y = XW'(i_y);
        n_p_z = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_p_x = XW'(i_y);
                n_p_y = -XW'(i_x);
                n_p_z = signed'(cfl_pkg::HALF_PI_Q60);
            end else begin
                n_p_x = -XW'(i_y);
                n_p_y = XW'(i_x);
                n_p_z = -signed'(cfl_pkg::HALF_PI_Q60);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_ce) begin
            r_p_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p_x    <= n_p_x;
            r_p_y    <= n_p_y;
            r_p_z    <= n_p_z;
            r_p_zero <= (i_x == 0) && (i_y == 0);
            r_p_pay  <= i_pay;
        end
    end

    // ---------------- CORDIC stages ----------------
    logic signed [XW-1:0] r_c_x    [0:N-1];
    logic signed [XW-1:0] r_c_y    [0:N-1];
    logic signed [63:0]   r_c_z    [0:N-1];
    logic                 r_c_zero [0:N-1];
    logic [PW-1:0]        r_c_pay  [0:N-1];
    logic                 r_c_vld  [0:N-1];

    for (genvar gk = 0; gk < N; gk++) begin : g_cordic
        localparam logic signed [63:0] TAB = signed'(cfl_pkg::atan_q60(gk));
        logic signed [XW-1:0] src_x, src_y, dx, dy;
        logic signed [63:0]   src_z;
        logic                 src_zero, src_vld;
        logic [PW-1:0]        src_pay;

        if (gk == 0) begin : g_first
            assign src_x    = r_p_x;
            assign src_y    = r_p_y;
            assign src_z    = r_p_z;
            assign src_zero = r_p_zero;
            assign src_pay  = r_p_pay;
            assign src_vld  = r_p_vld;
        end else begin : g_next
            assign src_x    = r_c_x[gk-1];
            assign src_y    = r_c_y[gk-1];
            assign src_z    = r_c_z[gk-1];
            assign src_zero = r_c_zero[gk-1];
            assign src_pay  = r_c_pay[gk-1];
            assign src_vld  = r_c_vld[gk-1];
        end

        assign dx = src_y >>> gk;
        assign dy = src_x >>> gk;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[gk] <= 1'b0;
            end else if (i_ce) begin
                r_c_vld[gk] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_c_zero[gk] <= src_zero;
                r_c_pay[gk]  <= src_pay;
                if (src_y >= 0) begin
                    r_c_x[gk] <= src_x + dx;
                    r_c_y[gk] <= src_y - dy;
                    r_c_z[gk] <= src_z + TAB;
                end else begin
                    r_c_x[gk] <= src_x - dx;
                    r_c_y[gk] <= src_y + dy;
                    r_c_z[gk] <= src_z - TAB;
                end
            end
        end
    end

    // ---------------- magnitude, then times 180 ----------------
    logic signed [63:0] n_m_zz, n_m_abs;
    logic [61:0]        r_m_mag;
    logic               r_m_neg;
    logic [PW-1:0]      r_m_pay;
    logic               r_m_vld;
    logic [PHW-1:0]     r_k_lo, r_k_hi;
    logic               r_k_neg;
    logic [PW-1:0]      r_k_pay;
    logic               r_k_vld;
    logic [NW-1:0]      r_n_num;
    logic               r_n_neg;
    logic [PW-1:0]      r_n_pay;
    logic               r_n_vld;

    always_comb begin
        n_m_zz  = r_c_zero[N-1] ? 64'sd0 : r_c_z[N-1];
        n_m_abs = n_m_zz[63] ? -n_m_zz : n_m_zz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_n_vld <= 1'b0;
        end else if (i_ce) begin
            r_m_vld <= r_c_vld[N-1];
            r_k_vld <= r_m_vld;
            r_n_vld <= r_k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_m_mag <= n_m_abs[61:0];
            r_m_neg <= n_m_zz[63];
            r_m_pay <= r_c_pay[N-1];
            // split product, two partial multiplies
            r_k_lo  <= PHW'(r_m_mag[30:0]) * PHW'(KDEG);
            r_k_hi  <= PHW'(r_m_mag[61:31]) * PHW'(KDEG);
            r_k_neg <= r_m_neg;
            r_k_pay <= r_m_pay;
            // rounding bias of half pi for the divide
            r_n_num <= (NW'(r_k_hi) << 31) + NW'(r_k_lo) + HPI_N;
            r_n_neg <= r_k_neg;
            r_n_pay <= r_k_pay;
        end
    end

    // ---------------- restoring divide by pi ----------------
    logic [NW-1:0] r_d_rem [0:QB-1];
    logic [QB-1:0] r_d_q   [0:QB-1];
    logic          r_d_neg [0:QB-1];
    logic [PW-1:0] r_d_pay [0:QB-1];
    logic          r_d_vld [0:QB-1];

    for (genvar gk = 0; gk < QB; gk++) begin : g_div
        localparam int B = QB - 1 - gk;
        localparam logic [NW-1:0] SUB = PI_N << B;
        logic [NW-1:0] src_rem;
        logic [QB-1:0] src_q;
        logic          src_neg, src_vld;
        logic [PW-1:0] src_pay;

        if (gk == 0) begin : g_first
            assign src_rem = r_n_num;
            assign src_q   = '0;
            assign src_neg = r_n_neg;
            assign src_pay = r_n_pay;
            assign src_vld = r_n_vld;
        end else begin : g_next
            assign src_rem = r_d_rem[gk-1];
            assign src_q   = r_d_q[gk-1];
            assign src_neg = r_d_neg[gk-1];
            assign src_pay = r_d_pay[gk-1];
            assign src_vld = r_d_vld[gk-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[gk] <= 1'b0;
            end else if (i_ce) begin
                r_d_vld[gk] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_d_neg[gk] <= src_neg;
                r_d_pay[gk] <= src_pay;
                if (src_rem >= SUB) begin
                    r_d_rem[gk] <= src_rem - SUB;
                    r_d_q[gk]   <= src_q | (QB'(1) << B);
                end else begin
                    r_d_rem[gk] <= src_rem;
                    r_d_q[gk]   <= src_q;
                end
            end
        end
    end

    // ---------------- sign back ----------------
    logic signed [DW-1:0] n_o_mag;
    logic signed [DW-1:0] r_o_deg;
    logic [PW-1:0]        r_o_pay;
    logic                 r_o_vld;

    assign n_o_mag = signed'({1'b0, r_d_q[QB-1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_ce) begin
            r_o_vld <= r_d_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_o_deg <= r_d_neg[QB-1] ? -n_o_mag : n_o_mag;
            r_o_pay <= r_d_pay[QB-1];
        end
    end

    assign o_vld = r_o_vld;
    assign o_deg = r_o_deg;
    assign o_pay = r_o_pay;

endmodule

/* src/cube_face_uv_to_latlon_unit.sv */
// ============================================================================
// cube_face_uv_to_latlon_unit - cube face (u,v) to unit vector and lat/lon
// Quadratic face warp, face axis permutation, normalization and two atan2
// units, all in a fully pipelined datapath.
// ============================================================================
// Pipeline: the bit-per-stage square roots (2 x 31), unit divides (31),
//   CORDIC (32) and degree divide (FRAC_BITS + 8), plus the warp, setup and
//   output registers.
// Throughput: one transaction per cycle; a stall at the output freezes the
//   whole pipe. Reset (sync, active low) clears all valid bits only.
module cube_face_uv_to_latlon_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [2:0] face, [19:3] u_coord, [36:20] v_coord
    input  logic [cfl_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [17:0] unit_x, [35:18] unit_y, [53:36] unit_z,
    // [77:54] latitude, [102:78] longitude
    output logic [cfl_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [0] face_ok
    output logic [0:0]                         o_m_tuser
);

    localparam int SH = cfl_pkg::WB - FRAC_BITS;
    localparam int DW = FRAC_BITS + 9;
    localparam logic [30:0] ONE_IN   = 31'd1 << FRAC_BITS;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
    localparam logic [31:0] RECIP3   = 32'hAAAA_AAAB;
    localparam logic [31:0] RND_ADD  = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;
    localparam logic signed [31:0] ONE_S = 32'sh4000_0000;

    logic r_out_vld;
    logic ce;
    assign ce         = !r_out_vld || i_m_tready;
    assign o_s_tready = ce;

    // ---------------- stage 1: saturate, fold about one half ----------------
    logic [16:0] w_c [0:1];
    logic [30:0] n1_t [0:1];
    logic        n1_neg [0:1];
    logic [30:0] r1_t [0:1];
    logic        r1_neg [0:1];
    logic [2:0]  r1_face;
    logic        r1_vld;

    assign w_c[0] = i_s_tdata[19:3];
    assign w_c[1] = i_s_tdata[36:20];

    always_comb begin
        logic [30:0] c31;
        logic [30:0] s;
        for (int j = 0; j < 2; j++) begin
            c31 = {14'd0, w_c[j]};
            if (c31 > ONE_IN) begin
                c31 = ONE_IN;
            end
            s         = c31 << SH;
            n1_neg[j] = s < HALF_Q30;
            n1_t[j]   = n1_neg[j] ? ONE_Q30 - s : s;
        end
    end

    // ---------------- stage 2: t squared ----------------
    logic [60:0] r2_tt [0:1];
    logic        r2_neg [0:1];
    logic [2:0]  r2_face;
    logic        r2_vld;
    logic [61:0] n2_sq [0:1];

    // ---------------- stage 3: (4t^2 - 1 + 3/2) / 2^30 ----------------
    logic [31:0] r3_m [0:1];
    logic        r3_neg [0:1];
    logic [2:0]  r3_face;
    logic        r3_vld;
    logic [62:0] n3_num [0:1];

    // ---------------- stage 4: divide by 3 via reciprocal ----------------
    logic [63:0] r4_p [0:1];
    logic        r4_neg [0:1];
    logic [2:0]  r4_face;
    logic        r4_vld;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n2_sq[j]  = {31'd0, r1_t[j]} * {31'd0, r1_t[j]};
            n3_num[j] = {r2_tt[j], 2'b00} - 63'h1000_0000_0000_0000 + 63'h6000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (ce) begin
            r1_vld <= i_s_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_face <= i_s_tdata[2:0];
            r2_face <= r1_face;
            r3_face <= r2_face;
            r4_face <= r3_face;
            for (int j = 0; j < 2; j++) begin
                r1_t[j]   <= n1_t[j];
                r1_neg[j] <= n1_neg[j];
                r2_tt[j]  <= n2_sq[j][60:0];
                r2_neg[j] <= r1_neg[j];
                r3_m[j]   <= n3_num[j][61:30];
                r3_neg[j] <= r2_neg[j];
                r4_p[j]   <= {32'd0, r3_m[j]} * {32'd0, RECIP3};
                r4_neg[j] <= r3_neg[j];
            end
        end
    end

    // ---------------- stage 5: signed warp, face permutation ----------------
    logic signed [31:0] n5_s [0:1];
    logic signed [31:0] n5_x, n5_y, n5_z;
    logic               n5_ok;
    logic signed [31:0] r5_v [0:2];
    logic               r5_ok;
    logic               r5_vld;

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            n5_s[j] = r4_neg[j] ? -signed'({1'b0, r4_p[j][63:33]})
                                :  signed'({1'b0, r4_p[j][63:33]});
        end
        n5_ok = 1'b1;
        unique case (r4_face)
            cfl_pkg::FACE_POS_X: begin
                n5_x = ONE_S;    n5_y = n5_s[0];  n5_z = n5_s[1];
            end
            cfl_pkg::FACE_POS_Y: begin
                n5_x = -n5_s[0]; n5_y = ONE_S;    n5_z = n5_s[1];
            end
            cfl_pkg::FACE_POS_Z: begin
                n5_x = -n5_s[0]; n5_y = -n5_s[1]; n5_z = ONE_S;
            end
            cfl_pkg::FACE_NEG_X: begin
                n5_x = -ONE_S;   n5_y = -n5_s[1]; n5_z = -n5_s[0];
            end
            cfl_pkg::FACE_NEG_Y: begin
                n5_x = n5_s[1];  n5_y = -ONE_S;   n5_z = -n5_s[0];
            end
            cfl_pkg::FACE_NEG_Z: begin
                n5_x = n5_s[1];  n5_y = n5_s[0];  n5_z = -ONE_S;
            end
            default: begin
                n5_x = '0; n5_y = '0; n5_z = '0; n5_ok = 1'b0;
            end
        endcase
    end

    // ---------------- stage 6: squares; stage 7: sum ----------------
    logic [61:0]        n6_sq [0:2];
    logic [61:0]        r6_sq [0:2];
    logic signed [31:0] r6_v [0:2];
    logic               r6_ok;
    logic               r6_vld;
    logic [61:0]        r7_sum;
    logic signed [31:0] r7_v [0:2];
    logic               r7_ok;
    logic               r7_vld;

    always_comb begin
        logic signed [31:0] a;
        for (int c = 0; c < 3; c++) begin
            a        = r5_v[c][31] ? -r5_v[c] : r5_v[c];
            n6_sq[c] = {31'd0, a[30:0]} * {31'd0, a[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (ce) begin
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_v[0] <= n5_x;
            r5_v[1] <= n5_y;
            r5_v[2] <= n5_z;
            r5_ok   <= n5_ok;
            r6_sq   <= n6_sq;
            r6_v    <= r5_v;
            r6_ok   <= r5_ok;
            r7_sum  <= r6_sq[0] + r6_sq[1] + r6_sq[2];
            r7_v    <= r6_v;
            r7_ok   <= r6_ok;
        end
    end

    // ---------------- vector norm ----------------
    logic        s1_vld;
    logic [30:0] s1_root;
    logic [96:0] s1_pay;

    cfl_isqrt #(.NW(62), .PW(97)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (r7_vld),
        .i_rad   (r7_sum),
        .i_pay   ({r7_ok, r7_v[2], r7_v[1], r7_v[0]}),
        .o_vld   (s1_vld),
        .o_root  (s1_root),
        .o_pay   (s1_pay)
    );

    // ---------------- divide setup: (|c| << 30) + r/2 ----------------
    logic signed [31:0] w_sv [0:2];
    logic [61:0]        n_d0_rem [0:2];
    logic [61:0]        r_d0_rem [0:2];
    logic [30:0]        r_d0_r;
    logic [2:0]         r_d0_sgn;
    logic               r_d0_ok;
    logic               r_d0_vld;

    assign w_sv[0] = s1_pay[31:0];
    assign w_sv[1] = s1_pay[63:32];
    assign w_sv[2] = s1_pay[95:64];

    always_comb begin
        logic signed [31:0] a;
        for (int c = 0; c < 3; c++) begin
            a           = w_sv[c][31] ? -w_sv[c] : w_sv[c];
            n_d0_rem[c] = ({31'd0, a[30:0]} << 30) + {32'd0, s1_root[30:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_vld <= 1'b0;
        end else if (ce) begin
            r_d0_vld <= s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_d0_rem <= n_d0_rem;
            r_d0_r   <= s1_root;
            r_d0_sgn <= {w_sv[2][31], w_sv[1][31], w_sv[0][31]};
            r_d0_ok  <= s1_pay[96];
        end
    end

    // ---------------- unit divides, one quotient bit per stage ----------------
    logic [61:0] r_dv_rem [0:30][0:2];
    logic [30:0] r_dv_q   [0:30][0:2];
    logic [30:0] r_dv_r   [0:30];
    logic [2:0]  r_dv_sgn [0:30];
    logic        r_dv_ok  [0:30];
    logic        r_dv_vld [0:30];

    for (genvar gk = 0; gk < 31; gk++) begin : g_div
        localparam int B = 30 - gk;
        logic [61:0] src_rem [0:2];
        logic [30:0] src_q   [0:2];
        logic [30:0] src_r;
        logic [2:0]  src_sgn;
        logic        src_ok, src_vld;
        logic [61:0] sub;

        if (gk == 0) begin : g_first
            assign src_rem = r_d0_rem;
            assign src_q   = '{default: '0};
            assign src_r   = r_d0_r;
            assign src_sgn = r_d0_sgn;
            assign src_ok  = r_d0_ok;
            assign src_vld = r_d0_vld;
        end else begin : g_next
            assign src_rem = r_dv_rem[gk-1];
            assign src_q   = r_dv_q[gk-1];
            assign src_r   = r_dv_r[gk-1];
            assign src_sgn = r_dv_sgn[gk-1];
            assign src_ok  = r_dv_ok[gk-1];
            assign src_vld = r_dv_vld[gk-1];
        end

        assign sub = {31'd0, src_r} << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[gk] <= 1'b0;
            end else if (ce) begin
                r_dv_vld[gk] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dv_r[gk]   <= src_r;
                r_dv_sgn[gk] <= src_sgn;
                r_dv_ok[gk]  <= src_ok;
                for (int c = 0; c < 3; c++) begin
                    if (src_rem[c] >= sub) begin
                        r_dv_rem[gk][c] <= src_rem[c] - sub;
                        r_dv_q[gk][c]   <= src_q[c] | (31'd1 << B);
                    end else begin
                        r_dv_rem[gk][c] <= src_rem[c];
                        r_dv_q[gk][c]   <= src_q[c];
                    end
                end
            end
        end
    end

    // ---------------- U1: signed units, squares, output rounding ----------------
    logic signed [31:0] n_u1_u   [0:2];
    logic signed [31:0] n_u1_rnd [0:2];
    logic signed [31:0] r_u1_u   [0:2];
    logic [61:0]        r_u1_sq  [0:1];
    logic [17:0]        r_u1_rnd [0:2];
    logic               r_u1_ok;
    logic               r_u1_vld;

    always_comb begin
        logic [31:0] m;
        logic [31:0] rm;
        for (int c = 0; c < 3; c++) begin
            m           = {1'b0, r_dv_q[30][c]};
            rm          = (m + RND_ADD) >> SH;
            n_u1_u[c]   = r_dv_sgn[30][c] ? -signed'(m) : signed'(m);
            n_u1_rnd[c] = r_dv_sgn[30][c] ? -signed'(rm) : signed'(rm);
        end
    end

    // ---------------- U2: horizontal sum of squares ----------------
    logic [61:0]        r_u2_sum;
    logic signed [31:0] r_u2_u   [0:2];
    logic [17:0]        r_u2_rnd [0:2];
    logic               r_u2_ok;
    logic               r_u2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1_vld <= 1'b0;
            r_u2_vld <= 1'b0;
        end else if (ce) begin
            r_u1_vld <= r_dv_vld[30];
            r_u2_vld <= r_u1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int c = 0; c < 3; c++) begin
                r_u1_u[c]   <= n_u1_u[c];
                r_u1_rnd[c] <= 18'(n_u1_rnd[c]);
            end
            for (int c = 0; c < 2; c++) begin
                r_u1_sq[c] <= {31'd0, r_dv_q[30][c]} * {31'd0, r_dv_q[30][c]};
            end
            r_u1_ok  <= r_dv_ok[30];
            r_u2_sum <= r_u1_sq[0] + r_u1_sq[1];
            r_u2_u   <= r_u1_u;
            r_u2_rnd <= r_u1_rnd;
            r_u2_ok  <= r_u1_ok;
        end
    end

    // ---------------- horizontal length ----------------
    logic         s2_vld;
    logic [30:0]  s2_root;
    logic [150:0] s2_pay;

    cfl_isqrt #(.NW(62), .PW(151)) u_hlen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (r_u2_vld),
        .i_rad   (r_u2_sum),
        .i_pay   ({r_u2_ok, r_u2_rnd[2], r_u2_rnd[1], r_u2_rnd[0],
                   r_u2_u[2], r_u2_u[1], r_u2_u[0]}),
        .o_vld   (s2_vld),
        .o_root  (s2_root),
        .o_pay   (s2_pay)
    );

    // ---------------- latitude and longitude ----------------
    logic                 lat_vld, lon_vld;
    logic signed [DW-1:0] lat_deg, lon_deg;
    logic [53:0]          lat_pay;
    logic [0:0]           lon_pay;

    cfl_atan_deg #(.FRAC_BITS(FRAC_BITS), .PW(54)) u_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s2_vld),
        .i_y     (s2_pay[95:64]),
        .i_x     (signed'({1'b0, s2_root})),
        .i_pay   (s2_pay[149:96]),
        .o_vld   (lat_vld),
        .o_deg   (lat_deg),
        .o_pay   (lat_pay)
    );

    cfl_atan_deg #(.FRAC_BITS(FRAC_BITS), .PW(1)) u_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s2_vld),
        .i_y     (s2_pay[63:32]),
        .i_x     (s2_pay[31:0]),
        .i_pay   (s2_pay[150:150]),
        .o_vld   (lon_vld),
        .o_deg   (lon_deg),
        .o_pay   (lon_pay)
    );

    // ---------------- output register, invalid faces read as zero ----------------
    logic [cfl_pkg::OUT_TDATA_W-1:0] n_out_data;
    logic [cfl_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                            r_out_ok;

    always_comb begin
        n_out_data = {1'b0,
                      cfl_pkg::LON_W'(lon_deg),
                      cfl_pkg::LAT_W'(lat_deg),
                      lat_pay[53:36], lat_pay[35:18], lat_pay[17:0]};
        if (!lon_pay[0]) begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= lat_vld && lon_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_data <= n_out_data;
            r_out_ok   <= lon_pay[0];
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_ok;

endmodule
